FILE: rtl/core/tlx_pkg.sv
package tlx_pkg;

   // offsets are tracked at this width and reported as their low 16 bits
   localparam int OFFSET_BITS = 16;
   localparam int OUT_BITS    = 16;
   localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

   // token queue between front and back, a power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic [4:0] K_EOF        = 5'd0;
   localparam logic [4:0] K_ERROR      = 5'd1;
   localparam logic [4:0] K_IDENT      = 5'd2;
   localparam logic [4:0] K_NUMBER     = 5'd3;
   localparam logic [4:0] K_STRING     = 5'd4;
   localparam logic [4:0] K_LPAREN     = 5'd5;
   localparam logic [4:0] K_RPAREN     = 5'd6;
   localparam logic [4:0] K_PLUS       = 5'd7;
   localparam logic [4:0] K_STAR       = 5'd8;
   localparam logic [4:0] K_SLASH      = 5'd9;
   localparam logic [4:0] K_DOT        = 5'd10;
   localparam logic [4:0] K_COMMA      = 5'd11;
   localparam logic [4:0] K_MINUS      = 5'd12;
   localparam logic [4:0] K_ARROW_R    = 5'd13;
   localparam logic [4:0] K_ARROW_L    = 5'd14;
   localparam logic [4:0] K_LESS       = 5'd15;
   localparam logic [4:0] K_LESS_EQ    = 5'd16;
   localparam logic [4:0] K_GREATER    = 5'd17;
   localparam logic [4:0] K_GREATER_EQ = 5'd18;
   localparam logic [4:0] K_EQUAL      = 5'd19;
   localparam logic [4:0] K_EQUAL_EQ   = 5'd20;
   localparam logic [4:0] K_TRUE       = 5'd21;
   localparam logic [4:0] K_FALSE      = 5'd22;
   localparam logic [4:0] K_FUNC       = 5'd23;

   typedef struct packed {
      logic [4:0]          kind;
      logic [OUT_BITS-1:0] start_pos;
      logic [OUT_BITS-1:0] end_pos;
   } token_type;

   // one queue entry holds the one or two tokens a single beat produced
   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic [OUT_BITS-1:0] to_out(input logic [OFFSET_BITS-1:0] off);
      logic [OFFSET_BITS+OUT_BITS-1:0] ext;
      begin
         ext = {{OUT_BITS{1'b0}}, off};
         return ext[OUT_BITS-1:0];
      end
   endfunction

endpackage

FILE: rtl/core/tlx_front.sv
module tlx_front
   import tlx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,
   input  logic [7:0]       req_tdata,
   input  queue_status_type q_status,
   output logic             push,
   output entry_type        push_entry
);

   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_IDENT   = 3'd1;
   localparam logic [2:0] M_NUMBER  = 3'd2;
   localparam logic [2:0] M_STRING  = 3'd3;
   localparam logic [2:0] M_MINUS   = 3'd4;
   localparam logic [2:0] M_LESS    = 3'd5;
   localparam logic [2:0] M_GREATER = 3'd6;
   localparam logic [2:0] M_EQUAL   = 3'd7;

   localparam logic [3:0] KW_NONE  = 4'd0;
   localparam logic [3:0] KW_F     = 4'd1;
   localparam logic [3:0] KW_FA    = 4'd2;
   localparam logic [3:0] KW_FAL   = 4'd3;
   localparam logic [3:0] KW_FALS  = 4'd4;
   localparam logic [3:0] KW_FALSE = 4'd5;
   localparam logic [3:0] KW_FU    = 4'd6;
   localparam logic [3:0] KW_FUN   = 4'd7;
   localparam logic [3:0] KW_FUNC  = 4'd8;
   localparam logic [3:0] KW_T     = 4'd9;
   localparam logic [3:0] KW_TR    = 4'd10;
   localparam logic [3:0] KW_TRU   = 4'd11;
   localparam logic [3:0] KW_TRUE  = 4'd12;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GREAT  = 8'h3E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_C      = 8'h63;
   localparam logic [7:0] CH_E      = 8'h65;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_L      = 8'h6C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_S      = 8'h73;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [3:0] kw_next(input logic [3:0] kp, input logic [7:0] c);
      logic [3:0] r;
      begin
         r = KW_NONE;
         unique case (kp)
            KW_F:    r = (c == CH_A) ? KW_FA : ((c == CH_U) ? KW_FU : KW_NONE);
            KW_FA:   r = (c == CH_L) ? KW_FAL : KW_NONE;
            KW_FAL:  r = (c == CH_S) ? KW_FALS : KW_NONE;
            KW_FALS: r = (c == CH_E) ? KW_FALSE : KW_NONE;
            KW_FU:   r = (c == CH_N) ? KW_FUN : KW_NONE;
            KW_FUN:  r = (c == CH_C) ? KW_FUNC : KW_NONE;
            KW_T:    r = (c == CH_R) ? KW_TR : KW_NONE;
            KW_TR:   r = (c == CH_U) ? KW_TRU : KW_NONE;
            KW_TRU:  r = (c == CH_E) ? KW_TRUE : KW_NONE;
            default: r = KW_NONE;
         endcase
         return r;
      end
   endfunction

   logic [2:0]             mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] begin_ff, begin_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [3:0]             kw_ff, kw_in;

   logic                   accept;
   logic [OFFSET_BITS-1:0] pos_next;
   logic                   pend_v;
   logic [4:0]             pend_kind;
   logic                   fl_v, pr_v, consumed;
   token_type              fl_tok, pr_tok;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign pos_next   = (pos_ff == OFF_MAX) ? pos_ff : pos_ff + OFFSET_BITS'(1);
   assign pend_v     = mode_ff != M_IDLE;

   // kind of the pending token if it is closed now
   always_comb begin
      pend_kind = K_EOF;
      unique case (mode_ff)
         M_IDENT: begin
            priority if (kw_ff == KW_FALSE) pend_kind = K_FALSE;
            else if (kw_ff == KW_FUNC) pend_kind = K_FUNC;
            else if (kw_ff == KW_TRUE) pend_kind = K_TRUE;
            else pend_kind = K_IDENT;
         end
         M_NUMBER:  pend_kind = K_NUMBER;
         M_STRING:  pend_kind = K_ERROR;
         M_MINUS:   pend_kind = K_MINUS;
         M_LESS:    pend_kind = K_LESS;
         M_GREATER: pend_kind = K_GREATER;
         M_EQUAL:   pend_kind = K_EQUAL;
         default:   pend_kind = K_EOF;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      begin_in = begin_ff;
      pos_in   = pos_ff;
      kw_in    = kw_ff;
      fl_v     = 1'b0;
      pr_v     = 1'b0;
      consumed = 1'b0;
      fl_tok   = '{kind: pend_kind, start_pos: to_out(begin_ff), end_pos: to_out(pos_ff)};
      pr_tok   = '{kind: K_EOF, start_pos: to_out(pos_ff), end_pos: to_out(pos_ff)};
      if (accept) begin
         if (req_tuser) begin
            // end of input: close pending token, then eof, then restart
            fl_v     = pend_v;
            pr_v     = 1'b1;
            mode_in  = M_IDLE;
            begin_in = '0;
            pos_in   = '0;
            kw_in    = KW_NONE;
         end else begin
            pr_tok.start_pos = to_out(begin_ff);
            pr_tok.end_pos   = to_out(pos_next);
            unique case (mode_ff)
               M_IDENT: begin
                  if (is_letter(req_tdata)) begin
                     consumed = 1'b1;
                     kw_in    = kw_next(kw_ff, req_tdata);
                  end
               end
               M_NUMBER: consumed = is_numeral(req_tdata);
               M_STRING: begin
                  consumed = 1'b1;
                  if (req_tdata == CH_QUOTE) begin
                     pr_v        = 1'b1;
                     pr_tok.kind = K_STRING;
                     mode_in     = M_IDLE;
                  end
               end
               M_MINUS: begin
                  if (req_tdata == CH_GREAT) begin
                     consumed    = 1'b1;
                     pr_v        = 1'b1;
                     pr_tok.kind = K_ARROW_R;
                     mode_in     = M_IDLE;
                  end
               end
               M_LESS: begin
                  if (req_tdata == CH_MINUS || req_tdata == CH_EQUAL) begin
                     consumed    = 1'b1;
                     pr_v        = 1'b1;
                     pr_tok.kind = (req_tdata == CH_MINUS) ? K_ARROW_L : K_LESS_EQ;
                     mode_in     = M_IDLE;
                  end
               end
               M_GREATER: begin
                  if (req_tdata == CH_EQUAL) begin
                     consumed    = 1'b1;
                     pr_v        = 1'b1;
                     pr_tok.kind = K_GREATER_EQ;
                     mode_in     = M_IDLE;
                  end
               end
               M_EQUAL: begin
                  if (req_tdata == CH_EQUAL) begin
                     consumed    = 1'b1;
                     pr_v        = 1'b1;
                     pr_tok.kind = K_EQUAL_EQ;
                     mode_in     = M_IDLE;
                  end
               end
               default: consumed = 1'b0;
            endcase

            if (!consumed) begin
               // close whatever is pending, then lex the byte from idle
               fl_v             = pend_v;
               mode_in          = M_IDLE;
               kw_in            = KW_NONE;
               pr_tok.start_pos = to_out(pos_ff);
               pr_tok.end_pos   = to_out(pos_next);
               unique case (req_tdata)
                  CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: pr_v = 1'b0;
                  CH_LPAREN: begin pr_v = 1'b1; pr_tok.kind = K_LPAREN; end
                  CH_RPAREN: begin pr_v = 1'b1; pr_tok.kind = K_RPAREN; end
                  CH_PLUS:   begin pr_v = 1'b1; pr_tok.kind = K_PLUS;   end
                  CH_STAR:   begin pr_v = 1'b1; pr_tok.kind = K_STAR;   end
                  CH_SLASH:  begin pr_v = 1'b1; pr_tok.kind = K_SLASH;  end
                  CH_DOT:    begin pr_v = 1'b1; pr_tok.kind = K_DOT;    end
                  CH_COMMA:  begin pr_v = 1'b1; pr_tok.kind = K_COMMA;  end
                  CH_QUOTE:  begin mode_in = M_STRING;  begin_in = pos_ff; end
                  CH_MINUS:  begin mode_in = M_MINUS;   begin_in = pos_ff; end
                  CH_LESS:   begin mode_in = M_LESS;    begin_in = pos_ff; end
                  CH_GREAT:  begin mode_in = M_GREATER; begin_in = pos_ff; end
                  CH_EQUAL:  begin mode_in = M_EQUAL;   begin_in = pos_ff; end
                  default: begin
                     priority if (is_letter(req_tdata)) begin
                        mode_in  = M_IDENT;
                        begin_in = pos_ff;
                        kw_in    = (req_tdata == CH_F) ? KW_F :
                                   ((req_tdata == CH_T) ? KW_T : KW_NONE);
                     end else if (is_numeral(req_tdata)) begin
                        mode_in  = M_NUMBER;
                        begin_in = pos_ff;
                     end else begin
                        pr_v        = 1'b1;
                        pr_tok.kind = K_ERROR;
                     end
                  end
               endcase
            end
            pos_in = pos_next;
         end
      end
   end

   // order the tokens: the closed pending token always goes first
   always_comb begin
      push              = fl_v || pr_v;
      push_entry.two    = fl_v && pr_v;
      push_entry.first  = fl_v ? fl_tok : pr_tok;
      push_entry.second = pr_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         begin_ff <= '0;
         pos_ff   <= '0;
         kw_ff    <= KW_NONE;
      end else begin
         mode_ff  <= mode_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
         kw_ff    <= kw_in;
      end
   end

endmodule

FILE: rtl/core/tlx_queue.sv
module tlx_queue
   import tlx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type q_status
);

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign q_status.empty = cnt_ff == '0;
   assign q_status.full  = cnt_ff == (PTR_BITS+1)'(QUEUE_DEPTH);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_entry     = mem_ff[rd_ptr_ff];

   // pointers wrap on their own since the depth is a power of two
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/tlx_back.sv
module tlx_back
   import tlx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  entry_type             head_entry,
   input  queue_status_type      q_status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [4:0]            rsp_tuser,
   output logic [2*OUT_BITS-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic      second_ff, second_in;
   logic      beat;
   token_type cur;

   assign rsp_tvalid = !q_status.empty;
   assign beat       = rsp_tvalid && rsp_tready;
   assign cur        = second_ff ? head_entry.second : head_entry.first;
   assign rsp_tuser  = cur.kind;
   assign rsp_tdata  = {cur.end_pos, cur.start_pos};
   assign rsp_tlast  = second_ff || !head_entry.two;

   // a two-token entry leaves the queue only after its second beat
   always_comb begin
      pop       = beat && rsp_tlast;
      second_in = second_ff;
      if (beat) begin
         second_in = !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

FILE: rtl/core/token_lexer_core.sv
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tuser: action, tdata: source_byte
// rsp_      out  rsp_tvalid/rsp_tready  tuser: token_kind, tdata: start, end; tlast: last
//
// one source byte per cycle is classified by the front unless the queue is full;
// closed tokens land in a four-entry queue; the back sends one token beat per cycle
// from the queue head while rsp_tready is high; a byte that closes two tokens takes
// two output beats, so the input keeps a rate of one per cycle until the queue fills,
// bounded by the output rate; tokens are registered in the queue before being sent
// reset is synchronous; it clears the lexer state, the offset and the queue
module token_lexer_core
   import tlx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // [0] action: 0 byte, 1 end of input
   input  logic [7:0]            req_tdata,   // [7:0] source_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [4:0]            rsp_tuser,   // [4:0] token_kind
   output logic [2*OUT_BITS-1:0] rsp_tdata,   // [15:0] token_start, [31:16] token_end
   output logic                  rsp_tlast    // last token caused by one input beat
);

   // front to queue
   logic             push;
   entry_type        push_entry;
   // queue to back
   entry_type        head_entry;
   queue_status_type q_status;
   logic             pop;

   // front: lexer state machine, at most two tokens per byte
   tlx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // short queue so each side can stall on its own
   tlx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // back: splits entries into single token beats
   tlx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // eof always closes the run of tokens of its input beat
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == K_EOF |-> rsp_tlast)
      else $error("eof token without tlast");

   // eof is an empty token
   a_eof_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == K_EOF |->
         rsp_tdata[OUT_BITS-1:0] == rsp_tdata[2*OUT_BITS-1:OUT_BITS])
      else $error("eof token with nonzero length");

   // with nothing queued the front must take input
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while the queue is empty");

   // end of input accepted while the queue is empty shows up next cycle
   a_eof_next: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser && !rsp_tvalid |=> rsp_tvalid)
      else $error("end of input produced no token");
`endif

endmodule
